>>> hdl/sgfd_pkg.sv
// Shared types, widths and codes for the sphere grid finite-difference block.
package sgfd_pkg;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 128;

    localparam int ROW_W      = 6;
    localparam int COL_W      = 7;
    localparam int SAMPLE_W   = 32;
    localparam int NR_W       = 7;
    localparam int NC_W       = 8;
    localparam int STEP_W     = 32;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [NR_W-1:0]   ROWS_RESET = 7'd64;
    localparam logic [NC_W-1:0]   COLS_RESET = 8'd128;
    localparam logic [STEP_W-1:0] STEP_RESET = 32'd1335088;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_ROW_STEP = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_COL_STEP = 4'd3;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;
    localparam logic DIR_LAT   = 1'b0;
    localparam logic DIR_LON   = 1'b1;

    typedef struct packed {
        logic                       action;
        logic [ROW_W-1:0]           row;
        logic [COL_W-1:0]           col;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       direction;
    } sgfd_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] derivative;
        logic                       saturated;
        logic                       bad_index;
    } sgfd_out_t;

    typedef struct packed {
        logic query;
        logic bad;
        logic centred;
        logic col_dir;
    } sgfd_ctrl_t;

endpackage

>>> hdl/sgfd_addr.sv
// Input stage and stencil address generation for the finite-difference pipeline.
module sgfd_addr #(
    parameter int MAX_ROWS = sgfd_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = sgfd_pkg::DEF_MAX_COLS,
    localparam int ADDR_W  = $clog2(MAX_ROWS * MAX_COLS)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  sgfd_pkg::sgfd_in_t                in_item,
    input  logic [sgfd_pkg::NR_W-1:0]         rows_in_use,
    input  logic [sgfd_pkg::NC_W-1:0]         cols_in_use,
    output logic                              out_valid,
    input  logic                              out_ready,
    output sgfd_pkg::sgfd_ctrl_t              out_ctrl,
    output logic [ADDR_W-1:0]                 out_addr_a,
    output logic [ADDR_W-1:0]                 out_addr_b,
    output logic signed [sgfd_pkg::SAMPLE_W-1:0] out_sample
);
    import sgfd_pkg::*;

    localparam int CALC_W = ADDR_W + NC_W;

    logic                       v1_reg;
    sgfd_in_t                   item_reg;
    logic                       v2_reg;
    sgfd_ctrl_t                 ctrl_reg;
    logic [ADDR_W-1:0]          addr_a_reg;
    logic [ADDR_W-1:0]          addr_b_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;

    logic              rdy1;
    logic              rdy2;
    logic [NR_W-1:0]   nr;
    logic [NC_W-1:0]   nc;
    logic [NR_W-1:0]   row_x;
    logic [NC_W-1:0]   col_x;
    logic              bad;
    logic              is_query;
    logic              centred;
    logic [NR_W-1:0]   ra;
    logic [NR_W-1:0]   rb;
    logic [NC_W-1:0]   ca;
    logic [NC_W-1:0]   cb;
    logic [ADDR_W-1:0] addr_a_next;
    logic [ADDR_W-1:0] addr_b_next;
    sgfd_ctrl_t        ctrl_next;

    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb begin
        if (rows_in_use < NR_W'(3)) begin
            nr = NR_W'(3);
        end else if (32'(rows_in_use) > 32'(MAX_ROWS)) begin
            nr = NR_W'(MAX_ROWS);
        end else begin
            nr = rows_in_use;
        end
        if (cols_in_use < NC_W'(3)) begin
            nc = NC_W'(3);
        end else if (32'(cols_in_use) > 32'(MAX_COLS)) begin
            nc = NC_W'(MAX_COLS);
        end else begin
            nc = cols_in_use;
        end
    end

    assign row_x    = {1'b0, item_reg.row};
    assign col_x    = {1'b0, item_reg.col};
    assign bad      = (row_x >= nr) || (col_x >= nc);
    assign is_query = (item_reg.action == ACT_QUERY);

    always_comb begin
        ra      = row_x;
        rb      = row_x;
        ca      = col_x;
        cb      = col_x;
        centred = 1'b1;
        if (is_query) begin
            if (item_reg.direction == DIR_LAT) begin
                if (row_x == '0) begin
                    ra      = NR_W'(1);
                    rb      = '0;
                    centred = 1'b0;
                end else if (row_x == nr - NR_W'(1)) begin
                    rb      = row_x - NR_W'(1);
                    centred = 1'b0;
                end else begin
                    ra = row_x + NR_W'(1);
                    rb = row_x - NR_W'(1);
                end
            end else begin
                ca = (col_x + NC_W'(1) == nc) ? '0 : col_x + NC_W'(1);
                cb = (col_x == '0) ? nc - NC_W'(1) : col_x - NC_W'(1);
            end
        end
    end

    assign addr_a_next = ADDR_W'(CALC_W'(ra) * CALC_W'(MAX_COLS) + CALC_W'(ca));
    assign addr_b_next = ADDR_W'(CALC_W'(rb) * CALC_W'(MAX_COLS) + CALC_W'(cb));

    always_comb begin
        ctrl_next.query   = is_query;
        ctrl_next.bad     = bad;
        ctrl_next.centred = centred;
        ctrl_next.col_dir = (item_reg.direction == DIR_LON);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            item_reg <= in_item;
        end
        if (rdy2 && v1_reg) begin
            ctrl_reg   <= ctrl_next;
            addr_a_reg <= addr_a_next;
            addr_b_reg <= addr_b_next;
            sample_reg <= item_reg.sample;
        end
    end

    assign out_valid  = v2_reg;
    assign out_ctrl   = ctrl_reg;
    assign out_addr_a = addr_a_reg;
    assign out_addr_b = addr_b_reg;
    assign out_sample = sample_reg;

endmodule

>>> hdl/sgfd_store.sv
// Sample store with one write port and two registered read ports.
module sgfd_store #(
    parameter int MAX_ROWS = sgfd_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = sgfd_pkg::DEF_MAX_COLS,
    localparam int DEPTH   = MAX_ROWS * MAX_COLS,
    localparam int ADDR_W  = $clog2(DEPTH)
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  sgfd_pkg::sgfd_ctrl_t                 in_ctrl,
    input  logic [ADDR_W-1:0]                    in_addr_a,
    input  logic [ADDR_W-1:0]                    in_addr_b,
    input  logic signed [sgfd_pkg::SAMPLE_W-1:0] in_sample,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output sgfd_pkg::sgfd_ctrl_t                 out_ctrl,
    output logic signed [sgfd_pkg::SAMPLE_W-1:0] out_rd_a,
    output logic signed [sgfd_pkg::SAMPLE_W-1:0] out_rd_b
);
    import sgfd_pkg::*;

    logic signed [SAMPLE_W-1:0] mem [DEPTH];

    logic                       v3_reg;
    sgfd_ctrl_t                 ctrl_reg;
    logic signed [SAMPLE_W-1:0] rd_a_reg;
    logic signed [SAMPLE_W-1:0] rd_b_reg;
    logic                       rdy3;
    logic                       take;

    assign rdy3     = !v3_reg || out_ready;
    assign in_ready = rdy3;
    assign take     = rdy3 && in_valid;

    // Write items end here; only queries travel on.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (rdy3) begin
            v3_reg <= in_valid && in_ctrl.query;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && !in_ctrl.query && !in_ctrl.bad) begin
            mem[in_addr_a] <= in_sample;
        end
        if (take && in_ctrl.query) begin
            rd_a_reg <= mem[in_addr_a];
            rd_b_reg <= mem[in_addr_b];
            ctrl_reg <= in_ctrl;
        end
    end

    assign out_valid = v3_reg;
    assign out_ctrl  = ctrl_reg;
    assign out_rd_a  = rd_a_reg;
    assign out_rd_b  = rd_b_reg;

endmodule

>>> hdl/sgfd_scale.sv
// Difference, step multiply, rounding shift and saturation stages.
module sgfd_scale (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  sgfd_pkg::sgfd_ctrl_t                 in_ctrl,
    input  logic signed [sgfd_pkg::SAMPLE_W-1:0] in_rd_a,
    input  logic signed [sgfd_pkg::SAMPLE_W-1:0] in_rd_b,
    input  logic [sgfd_pkg::STEP_W-1:0]          inv_row_step,
    input  logic [sgfd_pkg::STEP_W-1:0]          inv_col_step,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output sgfd_pkg::sgfd_out_t                  out_item
);
    import sgfd_pkg::*;

    localparam int PROD_W = SAMPLE_W + STEP_W;
    localparam int R_W    = PROD_W - 15;

    logic v4_reg;
    logic v5_reg;
    logic v6_reg;
    logic v7_reg;
    logic rdy4;
    logic rdy5;
    logic rdy6;
    logic rdy7;

    logic [SAMPLE_W-1:0] mag4_reg;
    logic                neg4_reg;
    sgfd_ctrl_t          ctrl4_reg;
    logic [PROD_W-1:0]   prod5_reg;
    logic                neg5_reg;
    sgfd_ctrl_t          ctrl5_reg;
    logic [R_W-1:0]      r6_reg;
    logic                neg6_reg;
    logic                bad6_reg;
    sgfd_out_t           out_reg;

    logic signed [SAMPLE_W:0] diff;
    logic [SAMPLE_W:0]        abs_diff;
    logic [SAMPLE_W-1:0]      mag4_next;
    logic                     neg4_next;
    logic [STEP_W-1:0]        step;
    logic [PROD_W-1:0]        prod5_next;
    logic [PROD_W:0]          rsum;
    logic [R_W-1:0]           r6_next;
    sgfd_out_t                out_next;

    assign rdy7     = !v7_reg || out_ready;
    assign rdy6     = !v6_reg || rdy7;
    assign rdy5     = !v5_reg || rdy6;
    assign rdy4     = !v4_reg || rdy5;
    assign in_ready = rdy4;

    assign diff     = {in_rd_a[SAMPLE_W-1], in_rd_a} - {in_rd_b[SAMPLE_W-1], in_rd_b};
    assign abs_diff = diff[SAMPLE_W] ? -diff : diff;

    // A difference of two 32-bit samples has a magnitude below 2^32.
    always_comb begin
        if (in_ctrl.bad) begin
            mag4_next = '0;
            neg4_next = 1'b0;
        end else begin
            mag4_next = abs_diff[SAMPLE_W-1:0];
            neg4_next = diff[SAMPLE_W];
        end
    end

    assign step       = ctrl4_reg.col_dir ? inv_col_step : inv_row_step;
    assign prod5_next = PROD_W'(mag4_reg) * PROD_W'(step);

    always_comb begin
        if (ctrl5_reg.centred) begin
            rsum    = {1'b0, prod5_reg} + (PROD_W + 1)'(32'h0001_0000);
            r6_next = {1'b0, rsum[PROD_W:17]};
        end else begin
            rsum    = {1'b0, prod5_reg} + (PROD_W + 1)'(32'h0000_8000);
            r6_next = rsum[PROD_W:16];
        end
    end

    always_comb begin
        out_next.bad_index = bad6_reg;
        if (neg6_reg) begin
            if (r6_reg > R_W'(33'h0_8000_0000)) begin
                out_next.derivative = 32'sh8000_0000;
                out_next.saturated  = 1'b1;
            end else begin
                out_next.derivative = -$signed(r6_reg[SAMPLE_W-1:0]);
                out_next.saturated  = 1'b0;
            end
        end else begin
            if (r6_reg > R_W'(33'h0_7FFF_FFFF)) begin
                out_next.derivative = 32'sh7FFF_FFFF;
                out_next.saturated  = 1'b1;
            end else begin
                out_next.derivative = $signed(r6_reg[SAMPLE_W-1:0]);
                out_next.saturated  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else begin
            if (rdy4) begin
                v4_reg <= in_valid;
            end
            if (rdy5) begin
                v5_reg <= v4_reg;
            end
            if (rdy6) begin
                v6_reg <= v5_reg;
            end
            if (rdy7) begin
                v7_reg <= v6_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy4 && in_valid) begin
            mag4_reg  <= mag4_next;
            neg4_reg  <= neg4_next;
            ctrl4_reg <= in_ctrl;
        end
        if (rdy5 && v4_reg) begin
            prod5_reg <= prod5_next;
            neg5_reg  <= neg4_reg;
            ctrl5_reg <= ctrl4_reg;
        end
        if (rdy6 && v5_reg) begin
            r6_reg   <= r6_next;
            neg6_reg <= neg5_reg;
            bad6_reg <= ctrl5_reg.bad;
        end
        if (rdy7 && v6_reg) begin
            out_reg <= out_next;
        end
    end

    assign out_valid = v7_reg;
    assign out_item  = out_reg;

endmodule

>>> hdl/sphere_grid_finite_difference.sv
// Throughput: one item per cycle while m_ready does not stall the output;
// the dual-read store serves both stencil neighbors at once.
// The seven register stages (input, address, store read, difference, multiply, round,
// output) each hold one item, so writes and queries may follow back to back.
// Reset clears all valid bits and loads the configuration reset values.
// Reset leaves the sample store untouched; its entries are undefined until written.
module sphere_grid_finite_difference #(
    parameter int MAX_ROWS = sgfd_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = sgfd_pkg::DEF_MAX_COLS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  sgfd_pkg::sgfd_in_t                  s_item,
    output logic                                m_valid,
    input  logic                                m_ready,
    output sgfd_pkg::sgfd_out_t                 m_item,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sgfd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sgfd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import sgfd_pkg::*;

    localparam int ADDR_W = $clog2(MAX_ROWS * MAX_COLS);

    logic [NR_W-1:0]   rows_reg;
    logic [NC_W-1:0]   cols_reg;
    logic [STEP_W-1:0] inv_row_step_reg;
    logic [STEP_W-1:0] inv_col_step_reg;

    logic                       a_valid;
    logic                       a_ready;
    sgfd_ctrl_t                 a_ctrl;
    logic [ADDR_W-1:0]          a_addr_a;
    logic [ADDR_W-1:0]          a_addr_b;
    logic signed [SAMPLE_W-1:0] a_sample;

    logic                       r_valid;
    logic                       r_ready;
    sgfd_ctrl_t                 r_ctrl;
    logic signed [SAMPLE_W-1:0] r_rd_a;
    logic signed [SAMPLE_W-1:0] r_rd_b;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg         <= ROWS_RESET;
            cols_reg         <= COLS_RESET;
            inv_row_step_reg <= STEP_RESET;
            inv_col_step_reg <= STEP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_ROWS_IN_USE: begin
                    rows_reg <= cfg_data[NR_W-1:0];
                end
                REG_COLS_IN_USE: begin
                    cols_reg <= cfg_data[NC_W-1:0];
                end
                REG_INV_ROW_STEP: begin
                    inv_row_step_reg <= cfg_data[STEP_W-1:0];
                end
                REG_INV_COL_STEP: begin
                    inv_col_step_reg <= cfg_data[STEP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    sgfd_addr #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_addr (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_item     (s_item),
        .rows_in_use (rows_reg),
        .cols_in_use (cols_reg),
        .out_valid   (a_valid),
        .out_ready   (a_ready),
        .out_ctrl    (a_ctrl),
        .out_addr_a  (a_addr_a),
        .out_addr_b  (a_addr_b),
        .out_sample  (a_sample)
    );

    sgfd_store #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (a_valid),
        .in_ready  (a_ready),
        .in_ctrl   (a_ctrl),
        .in_addr_a (a_addr_a),
        .in_addr_b (a_addr_b),
        .in_sample (a_sample),
        .out_valid (r_valid),
        .out_ready (r_ready),
        .out_ctrl  (r_ctrl),
        .out_rd_a  (r_rd_a),
        .out_rd_b  (r_rd_b)
    );

    sgfd_scale u_scale (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (r_valid),
        .in_ready     (r_ready),
        .in_ctrl      (r_ctrl),
        .in_rd_a      (r_rd_a),
        .in_rd_b      (r_rd_b),
        .inv_row_step (inv_row_step_reg),
        .inv_col_step (inv_col_step_reg),
        .out_valid    (m_valid),
        .out_ready    (m_ready),
        .out_item     (m_item)
    );

endmodule

>>> hdl/sgfd_checker.sv
// Port-level checker for the finite-difference block, bound to its top level.
module sgfd_props (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input sgfd_pkg::sgfd_out_t m_item
);

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("Block not empty and ready after reset.");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("Stalled result item changed or vanished.");

    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.bad_index |-> m_item.derivative == 32'sd0 && !m_item.saturated)
        else $error("Out-of-grid query returned a nonzero result.");

    a_sat_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.saturated |->
            m_item.derivative == 32'sh7FFF_FFFF || m_item.derivative == 32'sh8000_0000)
        else $error("Saturated result is not at a limit.");

endmodule

bind sphere_grid_finite_difference sgfd_props u_checker (.*);
